// ===== hw/rtl/sha512_pkg.sv =====
// sha512 package: item types, round constants and initial hash values
// used by the stream hasher top level; no dependencies
`default_nettype none
package sha512_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	localparam logic [63:0] INIT_HASH [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [6:0] LEN_POS  = 7'd112;

	function automatic logic [63:0] round_k(input logic [6:0] t);
		logic [63:0] k [80];
		k = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
		return k[t];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha512_stream_hasher.sv =====
// sha512 stream hasher: byte stream in, eight 64-bit digest words out
// depends on sha512_pkg
// a byte is taken while idle; a full block then runs the load, round and
// chain-add states, with stall held high meanwhile
// the last item pads one byte a cycle into the buffer (plus a second block
// when fewer than 17 bytes remain), then shows eight words
// asynchronous reset loads the initial hash values and clears all counters
`default_nettype none
module sha512_stream_hasher
	import sha512_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_data,
	input  wire logic      in_valid,
	output logic           in_stall,
	output out_item_t      out_data,
	output logic           out_valid,
	input  wire logic      out_stall
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_OUT
	} state_t;

	state_t      state_q;
	logic [63:0] chain_q [8];
	logic [63:0] wr_q [8];
	logic [63:0] win_q [16];
	logic [63:0] buf_q [16];
	logic [6:0]  fill_q;
	logic [127:0] len_q;
	logic [127:0] len_lat_q;
	logic [6:0]  rnd_q;
	logic        final_q;
	logic        pad_first_q;
	logic        pad_active_q;
	logic [2:0]  oidx_q;

	// one-round datapath
	logic [63:0] w, t1, t2, x2, x15, s0, s1, a, e, bw;
	logic [3:0]  ti, t2i, t7i, t15i;
	always_comb begin
		ti   = rnd_q[3:0];
		t2i  = ti - 4'd2;
		t7i  = ti - 4'd7;
		t15i = ti - 4'd15;
		bw   = buf_q[ti];
		x2  = win_q[t2i];
		x15 = win_q[t15i];
		s1 = {x2[18:0], x2[63:19]} ^ {x2[60:0], x2[63:61]} ^ (x2 >> 6);
		s0 = {x15[0], x15[63:1]} ^ {x15[7:0], x15[63:8]} ^ (x15 >> 7);
		w = (rnd_q < 7'd16) ? bw : s1 + win_q[t7i] + s0 + win_q[ti];
		a = wr_q[0];
		e = wr_q[4];
		t1 = wr_q[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
			+ (wr_q[6] ^ (e & (wr_q[5] ^ wr_q[6]))) + round_k(rnd_q) + w;
		t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
			+ ((a & wr_q[1]) | (wr_q[2] & (a | wr_q[1])));
	end

	// pad byte for the current fill position
	logic [7:0] pad_byte;
	logic [3:0] lsel;
	always_comb begin
		lsel = 4'd15 - fill_q[3:0];
		if (pad_first_q)
			pad_byte = PAD_BYTE;
		else if (fill_q >= LEN_POS && final_q)
			pad_byte = len_lat_q[{lsel, 3'd0} +: 8];
		else
			pad_byte = 8'd0;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	always_comb begin
		out_data.digest_word = chain_q[oidx_q];
		out_data.word_index  = oidx_q;
		out_data.last_word   = (oidx_q == 3'd7);
	end

	// block buffer as 16 big-endian words, one byte lane written per cycle
	logic [2:0] lane;
	assign lane = 3'd7 - fill_q[2:0];
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_data.byte_valid)
			buf_q[fill_q[6:3]][{lane, 3'd0} +: 8] <= in_data.data_byte;
		else if (state_q == ST_PAD)
			buf_q[fill_q[6:3]][{lane, 3'd0} +: 8] <= pad_byte;
	end

	// sequencer, rounds and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_HASH[i];
				wr_q[i] <= '0;
			end
			fill_q <= '0;
			len_q <= '0;
			len_lat_q <= '0;
			rnd_q <= '0;
			final_q <= 1'b0;
			pad_first_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_data.byte_valid) begin
							len_q <= len_q + 128'd8;
							fill_q <= fill_q + 7'd1;
						end
						if (in_data.last_byte) begin
							len_lat_q <= in_data.byte_valid ? len_q + 128'd8 : len_q;
							pad_first_q <= 1'b1;
							final_q <= 1'b0;
							// padding starts at the next fill position
							if (in_data.byte_valid && fill_q == 7'd127) begin
								state_q <= ST_LOAD;
							end else begin
								state_q <= ST_PAD;
							end
						end else if (in_data.byte_valid && fill_q == 7'd127) begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					// length field fits only if the 0x80 lands before it
					if (pad_first_q && fill_q <= 7'd111)
						final_q <= 1'b1;
					fill_q <= fill_q + 7'd1;
					if (fill_q == 7'd127)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					for (int i = 0; i < 8; i++)
						wr_q[i] <= chain_q[i];
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					win_q[ti] <= w;
					wr_q[7] <= wr_q[6];
					wr_q[6] <= wr_q[5];
					wr_q[5] <= wr_q[4];
					wr_q[4] <= wr_q[3] + t1;
					wr_q[3] <= wr_q[2];
					wr_q[2] <= wr_q[1];
					wr_q[1] <= wr_q[0];
					wr_q[0] <= t1 + t2;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79)
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++)
						chain_q[i] <= chain_q[i] + wr_q[i];
					rnd_q <= '0;
					if (final_q) begin
						oidx_q <= '0;
						state_q <= ST_OUT;
					end else if (pad_active_q) begin
						// a pending message end pads a fresh block that holds the length
						final_q <= 1'b1;
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++)
								chain_q[i] <= INIT_HASH[i];
							len_q <= '0;
							fill_q <= '0;
							final_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// message end pending: set on last item, cleared while the digest is output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pad_active_q <= 1'b0;
		else if (state_q == ST_IDLE && in_valid && in_data.last_byte)
			pad_active_q <= 1'b1;
		else if (state_q == ST_OUT)
			pad_active_q <= 1'b0;
	end

endmodule
`default_nettype wire
